[rtl/json_string_unescape_utf8_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the json string unescaper
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and codes of the json string unescaper
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // result kinds
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;

    // error codes
    localparam logic [3:0] E_NO_QUOTE   = 4'd0;
    localparam logic [3:0] E_CONTROL    = 4'd1;
    localparam logic [3:0] E_ESC_END    = 4'd2;
    localparam logic [3:0] E_BAD_ESC    = 4'd3;
    localparam logic [3:0] E_SHORT_HEX  = 4'd4;
    localparam logic [3:0] E_BAD_HEX    = 4'd5;
    localparam logic [3:0] E_NO_LOW     = 4'd6;
    localparam logic [3:0] E_BAD_LOW    = 4'd7;
    localparam logic [3:0] E_STRAY_LOW  = 4'd8;
    localparam logic [3:0] E_UNTERM     = 4'd9;

    // groups held between front and back
    localparam int QUEUE_DEPTH = 2;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]      kind;
        logic [3:0]      err;
        logic [1:0]      cnt;    // number of results minus one
        logic [3:0][7:0] bytes;
    } t_group;

endpackage

`default_nettype wire

[rtl/jsu_ifs.sv]
// ----------------------------------------------------------------------------
// jsu stream interfaces
// valid/ready channels for raw text items and decoded results
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output error_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input error_code,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// takes raw text items, tracks the string phase, builds result groups
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    jsu_in_if.sink          i_in,
    output logic            o_push_valid,
    output jsu_pkg::t_group o_push_group,
    input  wire             i_push_ready
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX1 = 3'd3;
    localparam logic [2:0] PH_BSL2 = 3'd4;
    localparam logic [2:0] PH_U2   = 3'd5;
    localparam logic [2:0] PH_HEX2 = 3'd6;

    // {ok, value}, value zero when not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_group encode(input logic [20:0] cp);
        t_group g;
        g = '0;
        g.kind = K_BYTE;
        if (cp <= 21'h7f) begin
            g.cnt      = 2'd0;
            g.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            g.cnt      = 2'd1;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            g.cnt      = 2'd2;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            g.cnt      = 2'd3;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    logic [2:0]  r_phase,  n_phase;
    logic [1:0]  r_digits, n_digits;
    logic [11:0] r_acc,    n_acc;
    logic [9:0]  r_high,   n_high;
    logic        r_bad,    n_bad;

    logic        accept;
    logic        has_result;
    logic        err_hit;
    logic [3:0]  err_code;
    logic [4:0]  hex;
    logic [15:0] unit;
    logic        bad_any;
    logic [10:0] pair_hi;
    t_group      grp;
    t_group      grp_out;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = i_push_ready;

    always_comb begin
        hex      = hex_digit(i_in.data_byte);
        unit     = {r_acc, hex[3:0]};
        bad_any  = r_bad | ~hex[4];
        pair_hi  = {1'b0, r_high} + 11'd64;
        n_phase  = r_phase;
        n_digits = r_digits;
        n_acc    = r_acc;
        n_high   = r_high;
        n_bad    = r_bad;
        grp      = '0;
        has_result = 1'b0;
        err_hit  = 1'b0;
        err_code = E_NO_QUOTE;

        if (i_in.mode) begin
            err_hit = 1'b1;
            case (r_phase)
                PH_BODY: err_code = E_UNTERM;
                PH_ESC:  err_code = E_ESC_END;
                PH_HEX1, PH_HEX2: err_code = E_SHORT_HEX;
                PH_BSL2, PH_U2:   err_code = E_NO_LOW;
                default: err_code = E_NO_QUOTE;
            endcase
        end else begin
            case (r_phase)
                PH_BODY: begin
                    if (i_in.data_byte == 8'h22) begin
                        n_phase    = PH_IDLE;
                        grp.kind   = K_DONE;
                        has_result = 1'b1;
                    end else if (i_in.data_byte < 8'h20) begin
                        err_hit  = 1'b1;
                        err_code = E_CONTROL;
                    end else if (i_in.data_byte == 8'h5c) begin
                        n_phase = PH_ESC;
                    end else begin
                        grp.kind     = K_BYTE;
                        grp.bytes[0] = i_in.data_byte;
                        has_result   = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase    = PH_BODY;
                    grp.kind   = K_BYTE;
                    has_result = 1'b1;
                    case (i_in.data_byte)
                        8'h22, 8'h5c, 8'h2f: grp.bytes[0] = i_in.data_byte;
                        8'h62: grp.bytes[0] = 8'h08;
                        8'h66: grp.bytes[0] = 8'h0c;
                        8'h6e: grp.bytes[0] = 8'h0a;
                        8'h72: grp.bytes[0] = 8'h0d;
                        8'h74: grp.bytes[0] = 8'h09;
                        8'h75: begin
                            n_phase    = PH_HEX1;
                            n_digits   = 2'd0;
                            n_acc      = '0;
                            n_bad      = 1'b0;
                            has_result = 1'b0;
                        end
                        default: begin
                            has_result = 1'b0;
                            err_hit    = 1'b1;
                            err_code   = E_BAD_ESC;
                        end
                    endcase
                end
                PH_BSL2: begin
                    if (i_in.data_byte != 8'h5c) begin
                        err_hit  = 1'b1;
                        err_code = E_NO_LOW;
                    end else begin
                        n_phase = PH_U2;
                    end
                end
                PH_U2: begin
                    if (i_in.data_byte != 8'h75) begin
                        err_hit  = 1'b1;
                        err_code = E_NO_LOW;
                    end else begin
                        n_phase  = PH_HEX2;
                        n_digits = 2'd0;
                        n_acc    = '0;
                        n_bad    = 1'b0;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (r_digits != 2'd3) begin
                        n_acc    = unit[11:0];
                        n_digits = r_digits + 2'd1;
                        n_bad    = bad_any;
                    end else if (bad_any) begin
                        err_hit  = 1'b1;
                        err_code = E_BAD_HEX;
                    end else begin
                        n_digits = 2'd0;
                        n_acc    = '0;
                        if (r_phase == PH_HEX1) begin
                            if (unit inside {[16'hd800:16'hdbff]}) begin
                                n_high  = unit[9:0];
                                n_phase = PH_BSL2;
                            end else if (unit inside {[16'hdc00:16'hdfff]}) begin
                                err_hit  = 1'b1;
                                err_code = E_STRAY_LOW;
                            end else begin
                                n_phase    = PH_BODY;
                                grp        = encode({5'd0, unit});
                                has_result = 1'b1;
                            end
                        end else begin
                            if (!(unit inside {[16'hdc00:16'hdfff]})) begin
                                err_hit  = 1'b1;
                                err_code = E_BAD_LOW;
                            end else begin
                                n_high     = '0;
                                n_phase    = PH_BODY;
                                grp        = encode({pair_hi, unit[9:0]});
                                has_result = 1'b1;
                            end
                        end
                    end
                end
                PH_IDLE: begin
                    if (i_in.data_byte == 8'h22) begin
                        n_phase = PH_BODY;
                    end else begin
                        err_hit  = 1'b1;
                        err_code = E_NO_QUOTE;
                    end
                end
                default: begin
                    err_hit  = 1'b1;
                    err_code = E_NO_QUOTE;
                end
            endcase
        end

        // any failure or finished string returns to reset state
        if (err_hit || (has_result && grp.kind == K_DONE)) begin
            n_phase  = PH_IDLE;
            n_digits = 2'd0;
            n_acc    = '0;
            n_high   = '0;
            n_bad    = 1'b0;
        end
        grp_out = grp;
        if (err_hit) begin
            grp_out      = '0;
            grp_out.kind = K_ERR;
            grp_out.err  = err_code;
            has_result   = 1'b1;
        end
    end

    assign o_push_valid = accept && has_result;
    assign o_push_group = grp_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_digits <= 2'd0;
            r_acc    <= '0;
            r_high   <= '0;
            r_bad    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_acc    <= n_acc;
            r_high   <= n_high;
            r_bad    <= n_bad;
        end
    end

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// short queue of result groups between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    input  jsu_pkg::t_group i_push_group,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output jsu_pkg::t_group o_pop_group,
    input  wire             i_pop_ready
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_group  = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// plays out one result group, one result per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_pop_valid,
    input  jsu_pkg::t_group i_pop_group,
    output logic            o_pop_ready,
    jsu_out_if.source       o_out
);
    import jsu_pkg::*;

    logic       r_busy;
    t_group     r_group;
    logic [1:0] r_idx;
    logic       at_last;
    logic       load;

    assign at_last     = (r_idx == r_group.cnt);
    assign o_pop_ready = !r_busy || (o_out.ready && at_last);
    assign load        = i_pop_valid && o_pop_ready;

    assign o_out.valid      = r_busy;
    assign o_out.kind       = r_group.kind;
    assign o_out.out_byte   = r_group.bytes[r_idx];
    assign o_out.error_code = r_group.err;
    assign o_out.last       = at_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_group <= i_pop_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (r_busy && o_out.ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/json_string_unescape_utf8.sv]
// path: a group is queued, then held in the back end until its last result leaves
// throughput: one input item per cycle while the group queue has room; results
//   leave at one per cycle while the receiver is ready; n results take n transfers
// the queue depth (groups) and the back end's one-result-per-cycle port set the rate
// reset: synchronous active low, clears phase, escape state and queue, no sweep
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// decodes a quoted json string body into utf-8 bytes, done and error results
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 #(
    parameter int P_QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);
    import jsu_pkg::*;

    // front to queue
    logic   push_valid;
    logic   push_ready;
    t_group push_group;

    // queue to back
    logic   pop_valid;
    logic   pop_ready;
    t_group pop_group;

    // front end: phase tracking, escape and \u decoding, utf-8 packing
    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_group (push_group),
        .i_push_ready (push_ready)
    );

    // short queue so a multi-byte group does not stall the front at once
    jsu_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_group (push_group),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_group  (pop_group),
        .i_pop_ready  (pop_ready)
    );

    // back end: one result per transfer, last marks the end of a group
    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_group (pop_group),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

    // front never offers a group the queue cannot take
    `JSU_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, push_valid, push_ready)
    // done and error results are always single and final
    `JSU_ASSERT_NOW(a_ctrl_is_last, i_clk, i_rst_n, o_out.valid && (o_out.kind != K_BYTE), o_out.last)
    // an idle back end picks up a waiting group at once
    `JSU_ASSERT_NEXT(a_back_picks_up, i_clk, i_rst_n, pop_valid && !o_out.valid, o_out.valid)

endmodule

`default_nettype wire

[sim/json_string_unescape_utf8_tb.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// drives raw text bytes and end-of-text marks into the unescaper and checks
// every decoded byte, done and error result against a directed table or a cycle-free decoder
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_tb;

    import jsu_pkg::*;

    // ascii codes the decoder and the sequence builder care about
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B,
                                             CH_F, CH_N, CH_R, CH_T};

    // utf-16 surrogate ranges
    localparam logic [15:0] SURR_HIGH_MIN = 16'hd800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hdbff;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hdc00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hdfff;

    // error field when the result is not an error
    localparam logic [3:0] NO_ERR = 4'd0;

    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD    = 400;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX_FIRST,
        SCAN_BSL_SECOND,
        SCAN_U_SECOND,
        SCAN_HEX_SECOND
    } t_scan_phase;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_COMB,
        RX_CHOKED
    } t_rx_style;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } t_text_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] err;
        logic       last;
    } t_result;

    // one directed row: the item, and where it is plain to see, its single
    // result (or that it gives none)
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       typed;
        logic       gives_one;
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] err;
    } t_dir_row;

    localparam int DIR_ROWS = 26;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // end of text and a zero byte while idle
        '{1'b1, 8'h00,    1'b1, 1'b1, K_ERR,  8'h00, E_NO_QUOTE},
        '{1'b0, 8'h00,    1'b1, 1'b1, K_ERR,  8'h00, E_NO_QUOTE},
        // open, then the top byte and the lowest printable byte pass through
        '{1'b0, CH_QUOTE, 1'b1, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'hff,    1'b1, 1'b1, K_BYTE, 8'hff, NO_ERR},
        '{1'b0, CH_SPACE, 1'b1, 1'b1, K_BYTE, 8'h20, NO_ERR},
        // highest control byte
        '{1'b0, 8'h1f,    1'b1, 1'b1, K_ERR,  8'h00, E_CONTROL},
        // text ends right after a backslash, data field ignored
        '{1'b0, CH_QUOTE, 1'b1, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_BSL,   1'b1, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b1, 8'hff,    1'b1, 1'b1, K_ERR,  8'h00, E_ESC_END},
        // \u0gF0: non-hex digit only reported after the fourth digit
        '{1'b0, CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_BSL,   1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_U,     1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h30,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h67,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h46,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h30,    1'b1, 1'b1, K_ERR,  8'h00, E_BAD_HEX},
        // \udBfF then a plain byte: high surrogate with no second unit
        '{1'b0, CH_QUOTE, 1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_BSL,   1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_U,     1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h64,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h42,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h66,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h46,    1'b0, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, 8'h61,    1'b1, 1'b1, K_ERR,  8'h00, E_NO_LOW},
        // empty string
        '{1'b0, CH_QUOTE, 1'b1, 1'b0, K_BYTE, 8'h00, NO_ERR},
        '{1'b0, CH_QUOTE, 1'b1, 1'b1, K_DONE, 8'h00, NO_ERR}
    };

    logic clk;
    logic rst_n;

    jsu_in_if  text_ch ();
    jsu_out_if result_ch ();

    json_string_unescape_utf8 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (text_ch),
        .o_out   (result_ch)
    );

    // decoder state, mirrors the block's registers
    t_scan_phase scan_ph;
    logic [1:0]  digit_cnt;
    logic [15:0] unit_acc;
    logic [9:0]  high_bits;
    logic        bad_digit;

    t_result     step_results    [$];   // results of the item just decoded
    t_result     pending_results [$];   // decoded results not yet seen at the output
    t_text_item  stim_seq        [$];   // random sequence being built

    int  mismatch_count = 0;
    int  burst_left     = 0;
    logic pressure_req  = 1'b0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // decoder
    // ------------------------------------------------------------------------

    function automatic void scan_clear();
        scan_ph   = SCAN_IDLE;
        digit_cnt = 2'd0;
        unit_acc  = 16'h0000;
        high_bits = 10'h000;
        bad_digit = 1'b0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] b, logic [3:0] err);
        t_result r;
        r = '{kind, b, err, 1'b0};
        step_results = {step_results, r};
    endfunction

    function automatic void scan_fail(logic [3:0] err);
        scan_clear();
        add_result(K_ERR, 8'h00, err);
    endfunction

    // bit 4 flags a valid hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'b0_0000;
    endfunction

    function automatic void add_utf8(logic [20:0] cp);
        if (cp <= 21'h7f) begin
            add_result(K_BYTE, cp[7:0], NO_ERR);
        end else if (cp <= 21'h7ff) begin
            add_result(K_BYTE, 8'hc0 | 8'(cp >> 6), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'(cp & 21'h3f), NO_ERR);
        end else if (cp <= 21'hffff) begin
            add_result(K_BYTE, 8'he0 | 8'(cp >> 12), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3f), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'(cp & 21'h3f), NO_ERR);
        end else begin
            add_result(K_BYTE, 8'hf0 | 8'((cp >> 18) & 21'h7), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'((cp >> 12) & 21'h3f), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'((cp >> 6) & 21'h3f), NO_ERR);
            add_result(K_BYTE, 8'h80 | 8'(cp & 21'h3f), NO_ERR);
        end
    endfunction

    // works out the results of one accepted item into step_results
    function automatic void decode_item(logic eot, logic [7:0] c);
        logic [4:0]  nib;
        logic [15:0] unit;
        logic [20:0] cp;
        step_results.delete();
        if (eot) begin
            case (scan_ph)
                SCAN_BODY:                       scan_fail(E_UNTERM);
                SCAN_ESC:                        scan_fail(E_ESC_END);
                SCAN_HEX_FIRST, SCAN_HEX_SECOND: scan_fail(E_SHORT_HEX);
                SCAN_BSL_SECOND, SCAN_U_SECOND:  scan_fail(E_NO_LOW);
                default:                         scan_fail(E_NO_QUOTE);
            endcase
        end else begin
            case (scan_ph)
                SCAN_IDLE: begin
                    if (c == CH_QUOTE) scan_ph = SCAN_BODY;
                    else scan_fail(E_NO_QUOTE);
                end
                SCAN_BODY: begin
                    if (c == CH_QUOTE) begin
                        scan_clear();
                        add_result(K_DONE, 8'h00, NO_ERR);
                    end else if (c < CH_SPACE) begin
                        scan_fail(E_CONTROL);
                    end else if (c == CH_BSL) begin
                        scan_ph = SCAN_ESC;
                    end else begin
                        add_result(K_BYTE, c, NO_ERR);
                    end
                end
                SCAN_ESC: begin
                    scan_ph = SCAN_BODY;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: add_result(K_BYTE, c, NO_ERR);
                        CH_B: add_result(K_BYTE, 8'h08, NO_ERR);
                        CH_F: add_result(K_BYTE, 8'h0c, NO_ERR);
                        CH_N: add_result(K_BYTE, 8'h0a, NO_ERR);
                        CH_R: add_result(K_BYTE, 8'h0d, NO_ERR);
                        CH_T: add_result(K_BYTE, 8'h09, NO_ERR);
                        CH_U: begin
                            scan_ph   = SCAN_HEX_FIRST;
                            digit_cnt = 2'd0;
                            unit_acc  = 16'h0000;
                            bad_digit = 1'b0;
                        end
                        default: scan_fail(E_BAD_ESC);
                    endcase
                end
                SCAN_BSL_SECOND: begin
                    if (c != CH_BSL) scan_fail(E_NO_LOW);
                    else scan_ph = SCAN_U_SECOND;
                end
                SCAN_U_SECOND: begin
                    if (c != CH_U) begin
                        scan_fail(E_NO_LOW);
                    end else begin
                        scan_ph   = SCAN_HEX_SECOND;
                        digit_cnt = 2'd0;
                        unit_acc  = 16'h0000;
                        bad_digit = 1'b0;
                    end
                end
                SCAN_HEX_FIRST, SCAN_HEX_SECOND: begin
                    nib = hex_nibble(c);
                    if (!nib[4]) bad_digit = 1'b1;
                    unit = {unit_acc[11:0], nib[4] ? nib[3:0] : 4'h0};
                    if (digit_cnt != 2'd3) begin
                        unit_acc  = unit;
                        digit_cnt = digit_cnt + 2'd1;
                    end else if (bad_digit) begin
                        scan_fail(E_BAD_HEX);
                    end else begin
                        digit_cnt = 2'd0;
                        unit_acc  = 16'h0000;
                        if (scan_ph == SCAN_HEX_FIRST) begin
                            if (unit >= SURR_HIGH_MIN && unit <= SURR_HIGH_MAX) begin
                                high_bits = unit[9:0];
                                scan_ph   = SCAN_BSL_SECOND;
                            end else if (unit >= SURR_LOW_MIN && unit <= SURR_LOW_MAX) begin
                                scan_fail(E_STRAY_LOW);
                            end else begin
                                scan_ph = SCAN_BODY;
                                add_utf8({5'd0, unit});
                            end
                        end else if (unit < SURR_LOW_MIN || unit > SURR_LOW_MAX) begin
                            scan_fail(E_BAD_LOW);
                        end else begin
                            cp        = 21'h10000 + {1'b0, high_bits, unit[9:0]};
                            high_bits = 10'h000;
                            scan_ph   = SCAN_BODY;
                            add_utf8(cp);
                        end
                    end
                end
                default: scan_fail(E_NO_QUOTE);
            endcase
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // random sequence builder
    // ------------------------------------------------------------------------

    function automatic void append_item(t_text_item it);
        stim_seq = {stim_seq, it};
    endfunction

    function automatic void push_text(logic [7:0] c);
        append_item('{1'b0, c});
    endfunction

    function automatic void push_eot();
        append_item('{1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
    endfunction

    function automatic logic [7:0] rand_not_hex();
        logic [7:0] c;
        logic [4:0] nib;
        do begin
            c   = 8'($urandom_range(0, 255));
            nib = hex_nibble(c);
        end while (nib[4]);
        return c;
    endfunction

    function automatic void push_unit(logic [15:0] u);
        push_text(CH_BSL);
        push_text(CH_U);
        push_text(hex_char(u[15:12]));
        push_text(hex_char(u[11:8]));
        push_text(hex_char(u[7:4]));
        push_text(hex_char(u[3:0]));
    endfunction

    // a unit outside the surrogate ranges, spread over the utf-8 lengths
    function automatic logic [15:0] rand_bmp_unit();
        logic [15:0] edges [8];
        edges = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                  16'h0800, 16'hd7ff, 16'he000, 16'hffff};
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(16'h0000, 16'h007f));
            1:       return 16'($urandom_range(16'h0080, 16'h07ff));
            2:       return 16'($urandom_range(16'h0800, 16'hd7ff));
            3:       return 16'($urandom_range(16'he000, 16'hffff));
            default: return edges[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [15:0] rand_high();
        return SURR_HIGH_MIN | 16'($urandom_range(0, 16'h03ff));
    endfunction

    function automatic logic [15:0] rand_low();
        return SURR_LOW_MIN | 16'($urandom_range(0, 16'h03ff));
    endfunction

    function automatic bit is_escape_char(logic [7:0] c);
        foreach (ESC_CHARS[k]) if (ESC_CHARS[k] == c) return 1'b1;
        return c == CH_U;
    endfunction

    function automatic void push_good_piece();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0, 1: begin
                do c = 8'($urandom_range(0, 255));
                while (c < CH_SPACE || c == CH_QUOTE || c == CH_BSL);
                push_text(c);
            end
            2: begin
                push_text(CH_BSL);
                push_text(ESC_CHARS[$urandom_range(0, 7)]);
            end
            4: begin
                push_unit(rand_high());
                push_unit(rand_low());
            end
            default: push_unit(rand_bmp_unit());
        endcase
    endfunction

    // one fault that ends the string
    function automatic void push_broken_piece();
        logic [7:0] c;
        logic [15:0] u;
        int bad_pos;
        int digits;
        case ($urandom_range(0, 11))
            0: push_text(8'($urandom_range(0, 8'h1f)));
            1: begin
                do c = 8'($urandom_range(0, 255)); while (is_escape_char(c));
                push_text(CH_BSL);
                push_text(c);
            end
            2: begin
                // bad digit somewhere among all four
                bad_pos = $urandom_range(0, 3);
                push_text(CH_BSL);
                push_text(CH_U);
                for (int p = 0; p < 4; p++)
                    push_text(p == bad_pos ? rand_not_hex() : hex_char(4'($urandom)));
            end
            3: begin
                // text ends inside the digits, with or without a bad one
                digits  = $urandom_range(0, 3);
                bad_pos = $urandom_range(0, 4);
                push_text(CH_BSL);
                push_text(CH_U);
                for (int p = 0; p < digits; p++)
                    push_text(p == bad_pos ? rand_not_hex() : hex_char(4'($urandom)));
                push_eot();
            end
            4: push_unit(rand_low());
            5: begin
                push_unit(rand_high());
                do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
                push_text(c);
            end
            6: begin
                push_unit(rand_high());
                push_text(CH_BSL);
                do c = 8'($urandom_range(0, 255)); while (c == CH_U);
                push_text(c);
            end
            7: begin
                push_unit(rand_high());
                u = $urandom_range(0, 1) ? rand_high() : rand_bmp_unit();
                push_unit(u);
            end
            8: begin
                push_unit(rand_high());
                push_eot();
            end
            9: begin
                push_unit(rand_high());
                push_text(CH_BSL);
                push_eot();
            end
            10: begin
                push_text(CH_BSL);
                push_eot();
            end
            default: push_eot();
        endcase
    endfunction

    // mostly well-formed strings, some broken, a few bursts of noise
    function automatic void build_sequence();
        int style;
        int pieces;
        int bad_at;
        stim_seq.delete();
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 3))
                append_item('{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
            return;
        end
        pieces = $urandom_range(0, 6);
        bad_at = (style <= 2) ? $urandom_range(0, pieces) : -1;
        push_text(CH_QUOTE);
        for (int k = 0; k <= pieces; k++) begin
            if (k == bad_at) begin
                push_broken_piece();
                return;
            end
            if (k < pieces) push_good_piece();
        end
        if ($urandom_range(0, 9) == 0) push_eot();
        else push_text(CH_QUOTE);
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offers one item, waits for its transfer, files its expected results and
    // then maybe idles for a while at the end of a burst
    task automatic send_item(input t_text_item it, input bit typed, input bit gives_one,
                             input t_result typed_res);
        text_ch.valid     <= 1'b1;
        text_ch.mode      <= it.mode;
        text_ch.data_byte <= it.data;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        decode_item(it.mode, it.data);
        if (typed) begin
            if (gives_one) pending_results = {pending_results, typed_res};
        end else begin
            pending_results = {pending_results, step_results};
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // stop offering until every filed result has come out
    task automatic hold_until_drained();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    initial begin
        int random_items;
        random_items = 0;
        text_ch.valid     <= 1'b0;
        text_ch.mode      <= 1'b0;
        text_ch.data_byte <= 8'h00;
        rst_n             <= 1'b0;
        scan_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_item('{DIR_TABLE[r].mode, DIR_TABLE[r].data}, DIR_TABLE[r].typed,
                      DIR_TABLE[r].gives_one,
                      '{DIR_TABLE[r].kind, DIR_TABLE[r].out_byte, DIR_TABLE[r].err, 1'b1});
        end
        hold_until_drained();

        // random part; the receiver starts with a long hold-off so the block
        // backs up while items keep being offered
        pressure_req <= 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= RANDOM_ITEMS / 2 && random_items < RANDOM_ITEMS / 2 + 8)
                hold_until_drained();
            build_sequence();
            foreach (stim_seq[k]) send_item(stim_seq[k], 1'b0, 1'b0, '0);
            random_items += stim_seq.size();
        end

        hold_until_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: changes stall style at random segment ends, and once holds
    // off for a long stretch when asked
    // ------------------------------------------------------------------------
    initial begin
        t_rx_style style;
        int        seg_left;
        int        tick;
        bit        held;
        style    = RX_OPEN;
        seg_left = 0;
        tick     = 0;
        held     = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_req && !held) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if (seg_left == 0) begin
                    style    = t_rx_style'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 80);
                end
                seg_left--;
                tick++;
                case (style)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_COMB:   result_ch.ready <= (tick % 4) != 0;
                    default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check: every transfer against the oldest filed result
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_result want;
        t_result got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.kind, result_ch.out_byte, result_ch.error_code, result_ch.last};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result kind=%0d byte=%h err=%0d last=%b",
                         $time, got.kind, got.out_byte, got.err, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t: expected kind=%0d byte=%h err=%0d last=%b, got kind=%0d byte=%h err=%0d last=%b",
                             $time, want.kind, want.out_byte, want.err, want.last,
                             got.kind, got.out_byte, got.err, got.last);
                end
            end
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
